// ----- design/sha1bh_pkg.sv -----
`default_nettype none
package sha1bh_pkg;

    localparam int COUNT_WIDTH = 61;
    localparam int QUEUE_DEPTH = 2;
    localparam int ROUNDS      = 80;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] POS_LAST  = 6'h3F;
    localparam logic [5:0] POS_LEN   = 6'd56;

    localparam logic [1:0] MODE_ABSORB     = 2'd0;
    localparam logic [1:0] MODE_ABSORB_FIN = 2'd1;
    localparam logic [1:0] MODE_FINISH     = 2'd2;
    localparam logic [1:0] MODE_UNUSED     = 2'd3;

    localparam logic [4:0][31:0] INIT_WORDS = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        status;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_ABSORB     = 2'd0,
        OP_ABSORB_FIN = 2'd1,
        OP_FINISH     = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20)      k = 32'h5A827999;
        else if (rnd < 7'd40) k = 32'h6ED9EBA1;
        else if (rnd < 7'd60) k = 32'h8F1BBCDC;
        else                  k = 32'hCA62C1D6;
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (rnd < 7'd20)      f = (b & c) | (~b & d);
        else if (rnd < 7'd40) f = b ^ c ^ d;
        else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                  f = b ^ c ^ d;
        return f;
    endfunction

endpackage
`default_nettype wire

// ----- design/sha1bh_front.sv -----
`default_nettype none
module sha1bh_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire sha1bh_pkg::t_in_item   i_item,
    output sha1bh_pkg::t_queue_head     o_head,
    input  wire logic                   i_pop
);
    sha1bh_pkg::t_cmd r_mem [sha1bh_pkg::QUEUE_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_full, w_acc, w_push, w_pop;
    sha1bh_pkg::t_cmd w_cmd;

    assign w_full  = (r_cnt == 2'(sha1bh_pkg::QUEUE_DEPTH));
    assign o_stall = w_full;
    assign w_acc   = i_valid && !w_full;

    // classify: unused mode is accepted and dropped
    always_comb begin
        w_cmd.data_byte = i_item.data_byte;
        unique case (i_item.mode)
            sha1bh_pkg::MODE_ABSORB:     w_cmd.op = sha1bh_pkg::OP_ABSORB;
            sha1bh_pkg::MODE_ABSORB_FIN: w_cmd.op = sha1bh_pkg::OP_ABSORB_FIN;
            default:                     w_cmd.op = sha1bh_pkg::OP_FINISH;
        endcase
    end

    assign w_push = w_acc && (i_item.mode == sha1bh_pkg::MODE_ABSORB ||
                              i_item.mode == sha1bh_pkg::MODE_ABSORB_FIN ||
                              i_item.mode == sha1bh_pkg::MODE_FINISH);
    assign w_pop  = i_pop && (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_cmd;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(sha1bh_pkg::QUEUE_DEPTH)) else $error("queue overfilled");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push) else $error("push into full queue");
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |=> (r_cnt <= 2'd1)) else $error("queue jumped");

endmodule
`default_nettype wire

// ----- design/sha1bh_core.sv -----
`default_nettype none
module sha1bh_core (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire sha1bh_pkg::t_queue_head i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output sha1bh_pkg::t_out_item       o_item
);
    typedef enum logic [2:0] {
        S_IDLE, S_FIN, S_PAD, S_ROUND, S_ADD, S_OUT, S_ERR
    } t_state;

    t_state                               r_state;
    logic [4:0][31:0]                     r_h;
    logic [31:0]                          r_a, r_b, r_c, r_d, r_e;
    logic [511:0]                         r_blk;
    logic [6:0]                           r_round;
    logic [5:0]                           r_pos;
    logic [sha1bh_pkg::COUNT_WIDTH-1:0]   r_count;
    logic                                 r_ovf, r_fin, r_pad_mode, r_first, r_len_go;
    logic [63:0]                          r_len;
    logic [2:0]                           r_idx;
    logic                                 r_ov;
    sha1bh_pkg::t_out_item                r_out;

    logic [31:0] w_w0, w_new, w_t;
    logic        w_slot, w_sel_len, w_emit;
    logic [7:0]  w_pad_byte;

    assign w_w0  = r_blk[511:480];
    // next schedule word from window taps t, t+2, t+8, t+13
    always_comb begin
        logic [31:0] x;
        x     = r_blk[511:480] ^ r_blk[447:416] ^ r_blk[255:224] ^ r_blk[95:64];
        w_new = {x[30:0], x[31]};
    end
    assign w_t = {r_a[26:0], r_a[31:27]} + sha1bh_pkg::round_f(r_round, r_b, r_c, r_d)
               + r_e + sha1bh_pkg::round_k(r_round) + w_w0;

    assign w_slot    = !r_ov || !i_stall;
    assign w_emit    = w_slot && (r_state == S_OUT || r_state == S_ERR);
    assign w_sel_len = !r_first && (r_pos == sha1bh_pkg::POS_LEN || r_len_go);
    assign w_pad_byte = r_first ? sha1bh_pkg::PAD_BYTE : (w_sel_len ? r_len[63:56] : 8'h00);

    assign o_pop   = (r_state == S_IDLE) && i_head.valid;
    assign o_valid = r_ov;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_h        <= sha1bh_pkg::INIT_WORDS;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_fin      <= 1'b0;
            r_pad_mode <= 1'b0;
            r_pos      <= '0;
            r_ov       <= 1'b0;
            r_first    <= 1'b0;
            r_len_go   <= 1'b0;
        end else begin
            if (w_emit)        r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        if (i_head.cmd.op == sha1bh_pkg::OP_FINISH) begin
                            r_state <= S_FIN;
                        end else begin
                            r_blk   <= {r_blk[503:0], i_head.cmd.data_byte};
                            r_pos   <= r_pos + 6'd1;
                            r_count <= r_count + sha1bh_pkg::COUNT_WIDTH'(1);
                            if (&r_count) r_ovf <= 1'b1;
                            r_fin   <= (i_head.cmd.op == sha1bh_pkg::OP_ABSORB_FIN);
                            if (r_pos == sha1bh_pkg::POS_LAST) begin
                                {r_a, r_b, r_c, r_d, r_e} <=
                                    {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                                r_round <= '0;
                                r_state <= S_ROUND;
                            end else if (i_head.cmd.op == sha1bh_pkg::OP_ABSORB_FIN) begin
                                r_state <= S_FIN;
                            end
                        end
                    end
                end
                S_FIN: begin
                    r_fin <= 1'b0;
                    if (r_ovf) begin
                        r_state <= S_ERR;
                    end else begin
                        r_len      <= 64'(r_count) << 3;
                        r_first    <= 1'b1;
                        r_len_go   <= 1'b0;
                        r_pad_mode <= 1'b1;
                        r_state    <= S_PAD;
                    end
                end
                S_PAD: begin
                    r_blk    <= {r_blk[503:0], w_pad_byte};
                    r_pos    <= r_pos + 6'd1;
                    r_first  <= 1'b0;
                    if (w_sel_len) begin
                        r_len_go <= 1'b1;
                        r_len    <= {r_len[55:0], 8'h00};
                    end
                    if (r_pos == sha1bh_pkg::POS_LAST) begin
                        {r_a, r_b, r_c, r_d, r_e} <= {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                        r_round <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_a     <= w_t;
                    r_b     <= r_a;
                    r_c     <= {r_b[1:0], r_b[31:2]};
                    r_d     <= r_c;
                    r_e     <= r_d;
                    r_blk   <= {r_blk[479:0], w_new};
                    r_round <= r_round + 7'd1;
                    if (r_round == 7'(sha1bh_pkg::ROUNDS - 1)) r_state <= S_ADD;
                end
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    r_idx  <= '0;
                    if (r_pad_mode) r_state <= r_len_go ? S_OUT : S_PAD;
                    else            r_state <= r_fin ? S_FIN : S_IDLE;
                end
                S_OUT: begin
                    if (w_slot) begin
                        r_out.digest_word <= r_h[r_idx];
                        r_out.word_index  <= r_idx;
                        r_out.last_word   <= (r_idx == 3'd4);
                        r_out.status      <= 1'b0;
                        r_idx             <= r_idx + 3'd1;
                        if (r_idx == 3'd4) begin
                            r_h        <= sha1bh_pkg::INIT_WORDS;
                            r_count    <= '0;
                            r_ovf      <= 1'b0;
                            r_pad_mode <= 1'b0;
                            r_pos      <= '0;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                S_ERR: begin
                    if (w_slot) begin
                        r_out.digest_word <= '0;
                        r_out.word_index  <= '0;
                        r_out.last_word   <= 1'b1;
                        r_out.status      <= 1'b1;
                        r_h        <= sha1bh_pkg::INIT_WORDS;
                        r_count    <= '0;
                        r_ovf      <= 1'b0;
                        r_pad_mode <= 1'b0;
                        r_pos      <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.word_index <= 3'd4)) else $error("word index out of range");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.status) |-> (o_item.last_word && o_item.word_index == 3'd0))
        else $error("error item malformed");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item))) else $error("output changed");
    a_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_round < 7'(sha1bh_pkg::ROUNDS))) else $error("round over");

endmodule
`default_nettype wire

// ----- design/sha1_byte_stream_hasher_top.sv -----
`default_nettype none
// SHA-1 byte stream hasher.
// Input channel (i_valid / o_stall / i_item): one item per message byte;
// mode 0 absorbs a byte, mode 1 absorbs a byte then finishes, mode 2
// finishes without a byte, mode 3 is accepted and dropped.
// Output channel (o_valid / i_stall / o_item): a finish yields five digest
// words, index 0 first, last_word on index 4; after a count overflow it
// yields one item with status 1 and a zero word instead.
// The back end takes a byte only in its idle state; every 64th byte
// starts the 80 SHA-1 rounds on one shared round datapath and the
// chaining add, when no byte is taken; a two-entry queue absorbs bursts.
// Finish with p bytes in the block: a setup step, 64 - p pad bytes
// (128 - p when p is 56 or more), one or two compressions, then one word
// per cycle through the output register unless the receiver stalls.
// Reset (synchronous, active low) loads the initial chaining words, clears
// the count, overflow flag, queue and output valid.
// A stalled receiver holds the output register; the core waits and the
// queue fills, after which o_stall goes high.
module sha1_byte_stream_hasher_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire sha1bh_pkg::t_in_item i_item,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output sha1bh_pkg::t_out_item     o_item
);
    sha1bh_pkg::t_queue_head w_head;
    logic                    w_pop;

    // front: accept and classify into the command queue
    sha1bh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    // back: buffer, pad, compress and emit
    sha1bh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule
`default_nettype wire

// ----- bench/tb_sha1_byte_stream_hasher_top.sv -----
`timescale 1ns / 1ps
// SHA-1 byte stream hasher bench.
// Messages go in one byte per item; every finish is predicted by a
// software SHA-1 held here, and each digest word coming out is compared
// field by field against the oldest pending word.
module tb_sha1_byte_stream_hasher_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 400;
    localparam int DRAIN_WAIT  = 400;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    sha1bh_pkg::t_in_item  i_item = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    sha1bh_pkg::t_out_item o_item;

    sha1_byte_stream_hasher_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    always #4 i_clk = ~i_clk;

    // ---------------- software SHA-1 ----------------
    logic [31:0]                        hash_words[5];
    logic [7:0]                         msg_block[64];
    logic [sha1bh_pkg::COUNT_WIDTH-1:0] msg_len;
    logic                               len_overflow;
    sha1bh_pkg::t_out_item              digest_q[$];

    int errors = 0;
    int words_seen = 0;
    int finishes = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic compress_block();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = hash_words[0]; b = hash_words[1]; c = hash_words[2];
        d = hash_words[3]; e = hash_words[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d;          k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;          k = 32'hCA62C1D6;
            end
            t = rotl(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rotl(b, 30); b = a; a = t;
        end
        hash_words[0] += a; hash_words[1] += b; hash_words[2] += c;
        hash_words[3] += d; hash_words[4] += e;
    endtask

    task automatic new_message();
        for (int i = 0; i < 5; i++) hash_words[i] = sha1bh_pkg::INIT_WORDS[i];
        msg_len = '0;
        len_overflow = 1'b0;
    endtask

    task automatic take_byte(input logic [7:0] v);
        logic [5:0] pos;
        pos = msg_len[5:0];
        msg_block[pos] = v;
        if (&msg_len) len_overflow = 1'b1;
        msg_len = msg_len + sha1bh_pkg::COUNT_WIDTH'(1);
        if (pos == sha1bh_pkg::POS_LAST) compress_block();
    endtask

    task automatic close_message();
        logic [63:0] bits;
        int pos;
        finishes++;
        if (len_overflow) begin
            digest_q.push_back('{digest_word: '0, word_index: '0, last_word: 1'b1,
                                 status: 1'b1});
            new_message();
            return;
        end
        bits = 64'(msg_len) << 3;
        pos = int'(msg_len[5:0]);
        msg_block[pos] = sha1bh_pkg::PAD_BYTE;
        pos++;
        if (pos > 56) begin
            while (pos < 64) begin
                msg_block[pos] = 8'h00; pos++;
            end
            compress_block();
            pos = 0;
        end
        while (pos < 56) begin
            msg_block[pos] = 8'h00; pos++;
        end
        for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 5; i++)
            digest_q.push_back('{digest_word: hash_words[i], word_index: 3'(i),
                                 last_word: (i == 4), status: 1'b0});
        new_message();
    endtask

    task automatic predict_item(input sha1bh_pkg::t_in_item it);
        case (it.mode)
            sha1bh_pkg::MODE_ABSORB:     take_byte(it.data_byte);
            sha1bh_pkg::MODE_ABSORB_FIN: begin
                take_byte(it.data_byte);
                close_message();
            end
            sha1bh_pkg::MODE_FINISH:     close_message();
            default: ;       // unused mode: dropped
        endcase
    endtask

    // ---------------- sender ----------------
    // Valid is raised independent of o_stall; an item is taken at the first
    // edge where o_stall was low.
    task automatic send_item(input sha1bh_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        predict_item(it);
    endtask

    // ---------------- receiver ----------------
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_request && hold_left == 0) hold_left = 600;
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ---------------- checker ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            words_seen++;
            if (digest_q.size() == 0) begin
                $display("%0t unexpected word: exp none got %h idx %0d last %b st %b", $time,
                         o_item.digest_word, o_item.word_index, o_item.last_word,
                         o_item.status);
                errors++;
            end else begin
                sha1bh_pkg::t_out_item want;
                want = digest_q.pop_front();
                if (want.digest_word !== o_item.digest_word)
                    $display("%0t digest_word: exp %h got %h", $time,
                             want.digest_word, o_item.digest_word);
                if (want.word_index !== o_item.word_index)
                    $display("%0t word_index: exp %0d got %0d", $time,
                             want.word_index, o_item.word_index);
                if (want.last_word !== o_item.last_word)
                    $display("%0t last_word: exp %b got %b", $time,
                             want.last_word, o_item.last_word);
                if (want.status !== o_item.status)
                    $display("%0t status: exp %b got %b", $time, want.status, o_item.status);
                if (want !== o_item) errors++;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cycles, digest_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- directed table ----------------
    typedef struct {
        logic [1:0]   mode;
        logic [7:0]   data_byte;
        bit           known;     // digest typed in below
        logic [159:0] digest;
    } t_row;

    localparam logic [159:0] EMPTY_SHA = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] ABC_SHA   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

    t_row rows[14];

    initial begin
        rows[0]  = '{sha1bh_pkg::MODE_FINISH,     8'hA5, 1, EMPTY_SHA};  // empty message
        rows[1]  = '{sha1bh_pkg::MODE_ABSORB,     "a",   0, '0};
        rows[2]  = '{sha1bh_pkg::MODE_ABSORB,     "b",   0, '0};
        rows[3]  = '{sha1bh_pkg::MODE_ABSORB_FIN, "c",   1, ABC_SHA};
        rows[4]  = '{sha1bh_pkg::MODE_UNUSED,     8'hFF, 0, '0};         // dropped
        rows[5]  = '{sha1bh_pkg::MODE_FINISH,     8'h00, 1, EMPTY_SHA};  // so still empty
        rows[6]  = '{sha1bh_pkg::MODE_ABSORB,     8'h00, 0, '0};
        rows[7]  = '{sha1bh_pkg::MODE_ABSORB,     8'hFF, 0, '0};
        rows[8]  = '{sha1bh_pkg::MODE_ABSORB_FIN, 8'h00, 0, '0};
        rows[9]  = '{sha1bh_pkg::MODE_ABSORB_FIN, 8'hFF, 0, '0};         // one byte message
        rows[10] = '{sha1bh_pkg::MODE_UNUSED,     8'h00, 0, '0};
        rows[11] = '{sha1bh_pkg::MODE_ABSORB,     8'h55, 0, '0};
        rows[12] = '{sha1bh_pkg::MODE_ABSORB,     8'hAA, 0, '0};
        rows[13] = '{sha1bh_pkg::MODE_FINISH,     8'hFF, 0, '0};
    end

    // random message: lengths pile up around the padding boundaries
    task automatic send_message(inout int sent);
        int len, pick;
        sha1bh_pkg::t_in_item it;
        pick = $urandom_range(9);
        case (pick)
            0:       len = $urandom_range(54, 57);
            1:       len = $urandom_range(62, 66);
            2:       len = $urandom_range(118, 130);
            3:       len = 0;
            default: len = $urandom_range(1, 40);
        endcase
        for (int i = 0; i < len; i++) begin
            // sprinkle dropped items as noise
            if ($urandom_range(15) == 0) begin
                it.mode = sha1bh_pkg::MODE_UNUSED; it.data_byte = 8'($urandom);
                send_item(it);
            end
            it.data_byte = 8'($urandom);
            it.mode = (i == len - 1 && $urandom_range(1)) ? sha1bh_pkg::MODE_ABSORB_FIN
                                                          : sha1bh_pkg::MODE_ABSORB;
            send_item(it);
            sent++;
            if (it.mode == sha1bh_pkg::MODE_ABSORB_FIN) return;
        end
        it.mode = sha1bh_pkg::MODE_FINISH; it.data_byte = 8'($urandom);
        send_item(it);
        sent++;
    endtask

    // ---------------- main sequence ----------------
    initial begin
        int sent;
        sha1bh_pkg::t_in_item it;
        new_message();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            it.mode = rows[r].mode;
            it.data_byte = rows[r].data_byte;
            send_item(it);
            if (rows[r].known) begin
                // swap the five predicted words for the typed-in digest
                repeat (5) void'(digest_q.pop_back());
                for (int i = 0; i < 5; i++)
                    digest_q.push_back('{digest_word: rows[r].digest[159-32*i -: 32],
                                         word_index: 3'(i), last_word: (i == 4),
                                         status: 1'b0});
            end
        end

        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            // long receiver hold-off while bytes keep coming: fills the queue
            if (ph == 0) hold_request <= 1'b1;
            while (sent < (ph + 1) * RAND_ITEMS / 4) begin
                send_message(sent);
                hold_request <= 1'b0;
            end
        end
        i_valid <= 1'b0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d messages, %0d digest words checked, random items %0d",
                 finishes, words_seen, sent);
        $display("idle mixes: none, sender 81%%, receiver 81%%, both 21%%, one long hold");
        if (errors == 0 && digest_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
